// ----- rtl/core/bap_pkg.sv -----
package bap_pkg;

   localparam logic [2:0] CMD_ABCD = 3'd0;
   localparam logic [2:0] CMD_SBCD = 3'd1;
   localparam logic [2:0] CMD_NBCD = 3'd2;
   localparam logic [2:0] CMD_PACK = 3'd3;
   localparam logic [2:0] CMD_UNPK = 3'd4;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] operand_a;
      logic [7:0]  operand_b;
      logic [15:0] adjust;
      logic        x_in;
      logic        z_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic        x_out;
      logic        carry_out;
      logic        z_out;
      logic        flags_changed;
   } rsp_type;

   // decimal value of a byte, digits 10..15 at face value (0..165)
   function automatic logic [7:0] dec_of(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return 8'((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
   endfunction

   // 0..99 to two BCD digits; tens by reciprocal multiply
   function automatic logic [7:0] enc_bcd(input logic [6:0] r);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = 15'({8'd0, r} * 15'd205);
      tens     = prod[14:11];
      tens_x10 = 7'(({3'd0, tens} << 3) + ({3'd0, tens} << 1));
      ones     = 7'(r - tens_x10);
      return {tens, ones[3:0]};
   endfunction

endpackage

// ----- rtl/core/bap_core.sv -----
module bap_core
   import bap_pkg::*;
(
   input  req_type item_in,
   output rsp_type item_out
);

   logic [7:0]        dec_a;
   logic [7:0]        dec_b;
   logic signed [9:0] d;
   logic signed [9:0] r_wide;
   logic [6:0]        r;
   logic [7:0]        bcd;
   logic              carry;
   logic [15:0]       pack_sum;
   logic [15:0]       unpk_sum;

   assign dec_a = dec_of(item_in.operand_a[7:0]);
   assign dec_b = dec_of(item_in.operand_b);

   always_comb begin
      unique case (item_in.cmd)
         CMD_ABCD: begin
            d = $signed({2'b00, dec_a}) + $signed({2'b00, dec_b})
                + $signed({9'd0, item_in.x_in});
            carry = (d >= 10'sd100);
         end
         CMD_SBCD: begin
            d = $signed({2'b00, dec_a}) - $signed({2'b00, dec_b})
                - $signed({9'd0, item_in.x_in});
            carry = (d < 10'sd0);
         end
         CMD_NBCD: begin
            d = 10'sd100 - $signed({2'b00, dec_a}) - $signed({9'd0, item_in.x_in});
            carry = (d != 10'sd100);
         end
         default: begin
            d     = 10'sd0;
            carry = 1'b0;
         end
      endcase
   end

   // wrap -166..331 into 0..99
   always_comb begin
      priority if (d >= 10'sd300) begin
         r_wide = d - 10'sd300;
      end else if (d >= 10'sd200) begin
         r_wide = d - 10'sd200;
      end else if (d >= 10'sd100) begin
         r_wide = d - 10'sd100;
      end else if (d >= 10'sd0) begin
         r_wide = d;
      end else if (d >= -10'sd100) begin
         r_wide = d + 10'sd100;
      end else begin
         r_wide = d + 10'sd200;
      end
   end

   assign r   = r_wide[6:0];
   assign bcd = enc_bcd(r);

   assign pack_sum = item_in.operand_a + item_in.adjust;
   assign unpk_sum = {4'd0, item_in.operand_a[7:4], 4'd0, item_in.operand_a[3:0]}
                     + item_in.adjust;

   always_comb begin
      item_out.result        = 16'd0;
      item_out.x_out         = item_in.x_in;
      item_out.carry_out     = 1'b0;
      item_out.z_out         = item_in.z_in;
      item_out.flags_changed = 1'b0;
      unique case (item_in.cmd)
         CMD_ABCD, CMD_SBCD, CMD_NBCD: begin
            item_out.result        = {8'd0, bcd};
            item_out.x_out         = carry;
            item_out.carry_out     = carry;
            item_out.z_out         = (bcd == 8'd0) ? item_in.z_in : 1'b0;
            item_out.flags_changed = 1'b1;
         end
         CMD_PACK: begin
            item_out.result = {8'd0, pack_sum[11:8], pack_sum[3:0]};
         end
         CMD_UNPK: begin
            item_out.result = unpk_sum;
         end
         default: begin
            item_out.result = 16'd0;
         end
      endcase
   end

endmodule

// ----- rtl/core/bcd_arith_pack_unit.sv -----
// Channel  Ports                           Direction  Carries
// req      req_valid req_ready req_item     in         operation, operands, X and Z
// rsp      rsp_valid rsp_ready rsp_item     out        value and new flags
//
// One item per cycle unless rsp stalls; rsp_valid rises once the result register loads.
// Input register, one pass of decimal logic, result register.
// Synchronous reset clears both valid bits; payload registers are not reset.
// A stalled rsp holds its item; the input stage keeps accepting while a free slot remains.
module bcd_arith_pack_unit
   import bap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_item_ff;
   rsp_type calc;
   logic    out_load;
   logic    in_load;

   bap_core u_core (
      .item_in  (in_item_ff),
      .item_out (calc)
   );

   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_load;
   assign in_load   = req_valid && req_ready;

   assign in_valid_in  = in_load ? 1'b1 : (in_valid_ff && !out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff <= req_item;
      end
      if (out_load && in_valid_ff) begin
         out_item_ff <= calc;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

import bap_pkg::*;

class bcd_scoreboard;
   rsp_type awaited_results[$];
   int      errors;

   function new();
      errors = 0;
   endfunction

   function rsp_type bcd_unit_result(req_type rq);
      rsp_type    rs;
      int         dest_val;
      int         src_val;
      int         diff;
      int         rem;
      logic [15:0] sum16;
      rs = '0;
      rs.x_out = rq.x_in;
      rs.z_out = rq.z_in;
      dest_val = 10 * int'(rq.operand_a[7:4]) + int'(rq.operand_a[3:0]);
      src_val = 10 * int'(rq.operand_b[7:4]) + int'(rq.operand_b[3:0]);
      diff = 0;
      case (rq.cmd)
         CMD_ABCD: begin
            diff = dest_val + src_val + int'(rq.x_in);
            rs.carry_out = (diff >= 100);
         end
         CMD_SBCD: begin
            diff = dest_val - src_val - int'(rq.x_in);
            rs.carry_out = (diff < 0);
         end
         CMD_NBCD: begin
            diff = 100 - dest_val - int'(rq.x_in);
            rs.carry_out = (diff != 100);
         end
         CMD_PACK: begin
            sum16 = rq.operand_a + rq.adjust;
            rs.result = {8'h00, sum16[11:8], sum16[3:0]};
         end
         CMD_UNPK: begin
            rs.result = {4'h0, rq.operand_a[7:4], 4'h0, rq.operand_a[3:0]} + rq.adjust;
         end
         default: begin
         end
      endcase
      if (rq.cmd == CMD_ABCD || rq.cmd == CMD_SBCD || rq.cmd == CMD_NBCD) begin
         // decimal wrap to 0..99, negative remainders folded up
         rem = diff % 100;
         if (rem < 0) rem += 100;
         rs.result = {8'h00, 4'(rem / 10), 4'(rem % 10)};
         rs.x_out = rs.carry_out;
         rs.z_out = rq.z_in & (rs.result == 16'h0000);
         rs.flags_changed = 1'b1;
      end
      return rs;
   endfunction

   function void note_request(req_type rq);
      awaited_results.push_back(bcd_unit_result(rq));
   endfunction

   task report(string msg);
      if (errors < 100) $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         report($sformatf("item with nothing pending, result=%h", got.result));
         return;
      end
      want = awaited_results.pop_front();
      if (got.result !== want.result)
         report($sformatf("result %h, want %h", got.result, want.result));
      if (got.x_out !== want.x_out)
         report($sformatf("x_out %b, want %b (result %h)", got.x_out, want.x_out, want.result));
      if (got.carry_out !== want.carry_out)
         report($sformatf("carry_out %b, want %b (result %h)", got.carry_out, want.carry_out,
                          want.result));
      if (got.z_out !== want.z_out)
         report($sformatf("z_out %b, want %b (result %h)", got.z_out, want.z_out, want.result));
      if (got.flags_changed !== want.flags_changed)
         report($sformatf("flags_changed %b, want %b (result %h)", got.flags_changed,
                          want.flags_changed, want.result));
   endtask
endclass

module testbench;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int BLOCK_ITEMS = 100;
   localparam logic [2:0] CMD_RSVD5 = 3'd5;
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_item;
   bit      quiet;

   bcd_scoreboard sb;

   bcd_arith_pack_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      if (pick < 9) return 8'($urandom);
      return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h99;
   endfunction

   function automatic req_type mk(logic [2:0] cmd, logic [15:0] a, logic [7:0] b,
                                  logic [15:0] adj, logic x, logic z);
      req_type rq;
      rq.cmd = cmd;
      rq.operand_a = a;
      rq.operand_b = b;
      rq.adjust = adj;
      rq.x_in = x;
      rq.z_in = z;
      return rq;
   endfunction

   function automatic req_type random_request();
      req_type rq;
      if ($urandom_range(0, 19) < 18) rq.cmd = 3'($urandom_range(CMD_ABCD, CMD_UNPK));
      else rq.cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      rq.operand_a = {8'($urandom), rand_byte()};
      if (rq.cmd == CMD_PACK && $urandom_range(0, 1) != 0) rq.operand_a = 16'($urandom);
      rq.operand_b = rand_byte();
      case ($urandom_range(0, 7))
         0: rq.adjust = 16'h0000;
         1: rq.adjust = 16'hFFFF;
         default: rq.adjust = 16'($urandom);
      endcase
      rq.x_in = 1'($urandom);
      rq.z_in = 1'($urandom);
      return rq;
   endfunction

   task automatic send_item(req_type rq);
      int gap;
      req_item <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(rq);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic hold_off();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.awaited_results.size() != 0);
   endtask

   initial begin : drain
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_item);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 15) stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   initial begin : stimulus
      req_type directed[$];
      sb = new();
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed = '{
         mk(CMD_ABCD, 16'h0099, 8'h99, 16'h0000, 1'b1, 1'b1),
         mk(CMD_ABCD, 16'h0000, 8'h00, 16'hFFFF, 1'b0, 1'b1),
         mk(CMD_ABCD, 16'hFFFF, 8'hFF, 16'h0000, 1'b1, 1'b0),
         mk(CMD_ABCD, 16'hAB50, 8'h50, 16'h0000, 1'b0, 1'b1),
         mk(CMD_ABCD, 16'h0012, 8'h34, 16'h0000, 1'b0, 1'b1),
         mk(CMD_SBCD, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1),
         mk(CMD_SBCD, 16'h0000, 8'h01, 16'h0000, 1'b1, 1'b1),
         mk(CMD_SBCD, 16'hFF00, 8'hFF, 16'h0000, 1'b1, 1'b0),
         mk(CMD_SBCD, 16'h0099, 8'h99, 16'h0000, 1'b0, 1'b1),
         mk(CMD_SBCD, 16'h00FF, 8'h00, 16'h0000, 1'b0, 1'b1),
         mk(CMD_NBCD, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1),
         mk(CMD_NBCD, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1),
         mk(CMD_NBCD, 16'h0050, 8'h00, 16'h0000, 1'b0, 1'b0),
         mk(CMD_NBCD, 16'h00FF, 8'h00, 16'h0000, 1'b1, 1'b1),
         mk(CMD_NBCD, 16'h0099, 8'h00, 16'h0000, 1'b0, 1'b1),
         mk(CMD_NBCD, 16'h00A0, 8'h00, 16'h0000, 1'b0, 1'b1),
         mk(CMD_PACK, 16'hFFFF, 8'h00, 16'hFFFF, 1'b1, 1'b1),
         mk(CMD_PACK, 16'h0000, 8'hFF, 16'h0000, 1'b0, 1'b0),
         mk(CMD_PACK, 16'h1234, 8'h00, 16'h0F0F, 1'b1, 1'b0),
         mk(CMD_UNPK, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 1'b1),
         mk(CMD_UNPK, 16'h00FF, 8'h00, 16'hF0F0, 1'b1, 1'b0),
         mk(CMD_UNPK, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0),
         mk(CMD_RSVD5, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1),
         mk(CMD_RSVD6, 16'h1234, 8'h56, 16'h789A, 1'b0, 1'b1),
         mk(CMD_RSVD7, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0)
      };
      foreach (directed[i]) send_item(directed[i]);
      hold_off();

      for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < BLOCK_ITEMS; n++) send_item(random_request());
         if (blk % 5 == 4) hold_off();
      end
      quiet = 1'b0;
      hold_off();
      repeat (8) @(posedge clock);

      if (sb.errors == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end
endmodule
